>>> hdl/bsf_pkg.sv
// Package for the bond stress failure check core.
// Widths, register indexes, cause codes and small arithmetic helpers.
// No dependencies.
package bsf_pkg;

  localparam int unsigned CompBits = 21;
  localparam int unsigned NormFrac = CompBits - 2;
  localparam int unsigned VecBits  = 63;
  localparam int unsigned LifeBits = 17;
  localparam int unsigned RegBits  = 32;
  localparam int unsigned IdxBits  = 3;
  localparam int unsigned InBits   = 7 * VecBits + LifeBits;
  localparam int unsigned InBytes  = (InBits + 7) / 8;
  localparam int unsigned OutBits  = 32 + 31 + 1 + 2;
  localparam int unsigned OutBytes = (OutBits + 7) / 8;

  localparam logic [IdxBits-1:0] RegKn = 3'd0;
  localparam logic [IdxBits-1:0] RegKs = 3'd1;
  localparam logic [IdxBits-1:0] RegT  = 3'd2;
  localparam logic [IdxBits-1:0] RegC  = 3'd3;
  localparam logic [IdxBits-1:0] RegU  = 3'd4;
  localparam logic [IdxBits-1:0] RegF  = 3'd5;

  localparam logic [1:0] CauseNone    = 2'd0;
  localparam logic [1:0] CauseTensile = 2'd1;
  localparam logic [1:0] CauseShear   = 2'd2;
  localparam logic [1:0] CauseComp    = 2'd3;

  typedef logic signed [CompBits-1:0] comp_t;

  typedef struct packed {
    logic [RegBits-1:0] kn;
    logic [RegBits-1:0] ks;
    logic [RegBits-1:0] ten;
    logic [RegBits-1:0] coh;
    logic [RegBits-1:0] comp;
    logic [RegBits-1:0] fric;
  } cfg_t;

  function automatic comp_t get_comp(input logic [VecBits-1:0] w, input int unsigned k);
    return comp_t'(w[k*CompBits +: CompBits]);
  endfunction

endpackage

>>> hdl/bsf_sqrt_pipe.sv
// Pipelined floor square root, four result bits per stage.
// Depends on bsf_pkg. Carries a side payload alongside the radicand.
module bsf_sqrt_pipe
  import bsf_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         en_i,
  input  logic         valid_i,
  input  logic [63:0]  rad_i,
  input  logic [191:0] side_i,
  output logic         valid_o,
  output logic [31:0]  root_o,
  output logic [191:0] side_o
);
  localparam int unsigned NStg = 8;
  logic [63:0]     rem_q  [NStg];
  logic [31:0]     root_q [NStg];
  logic [191:0]    side_q [NStg];
  logic [NStg-1:0] vld_q;

  for (genvar g = 0; g < NStg; g++) begin : g_stg
    logic [63:0]  rem_in;
    logic [31:0]  root_in;
    logic [191:0] side_in;
    logic         vld_in;
    logic [63:0]  rem_d;
    logic [31:0]  root_d;
    if (g == 0) begin : g_head
      assign rem_in  = rad_i;
      assign root_in = '0;
      assign side_in = side_i;
      assign vld_in  = valid_i;
    end else begin : g_body
      assign rem_in  = rem_q[g-1];
      assign root_in = root_q[g-1];
      assign side_in = side_q[g-1];
      assign vld_in  = vld_q[g-1];
    end
    always_comb begin
      logic [63:0] r;
      logic [31:0] q;
      logic [65:0] trial;
      r = rem_in;
      q = root_in;
      for (int b = 0; b < 4; b++) begin
        trial = {32'd0, q, 2'b01} << (2 * (31 - (g * 4 + b)));
        if ({2'b0, r} >= trial) begin
          r = r - trial[63:0];
          q = {q[30:0], 1'b1};
        end else begin
          q = {q[30:0], 1'b0};
        end
      end
      rem_d  = r;
      root_d = q;
    end
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[g] <= 1'b0;
      end else if (en_i) begin
        vld_q[g] <= vld_in;
      end
    end
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[g]  <= rem_d;
        root_q[g] <= root_d;
        side_q[g] <= side_in;
      end
    end
  end

  assign valid_o = vld_q[NStg-1];
  assign root_o  = root_q[NStg-1];
  assign side_o  = side_q[NStg-1];
endmodule

>>> hdl/bond_stress_failure_check_core.sv
// Top level of the bond stress failure check core.
// Depends on bsf_pkg and bsf_sqrt_pipe.
// Channel   Dir  Payload
// s_axis    in   tdata: 7 vectors of 63 bits then 17-bit life
// m_axis    out  tdata: normal_stress, shear_stress, broken, cause
// cfg       in   we, index, 32-bit data
// One transaction per cycle sustained while not stalled; results pass through
// the 8-stage root and the multiply/product stages. The pipeline advances when
// the output register is empty or being taken; a stall freezes every stage.
// Reset clears valid bits and loads register defaults.
module bond_stress_failure_check_core
  import bsf_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // shift_first, turn_first, shift_second, turn_second, arm_first, arm_second,
  // face_normal, life
  input  logic [InBytes*8-1:0]  s_axis_tdata,
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // normal_stress, shear_stress, broken, cause
  output logic [OutBytes*8-1:0] m_axis_tdata,
  input  logic                  cfg_we_i,
  input  logic [IdxBits-1:0]    cfg_index_i,
  input  logic [RegBits-1:0]    cfg_data_i
);
  cfg_t cfg_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{kn: 32'd65536, ks: 32'd32768, ten: 32'd65536, coh: 32'd65536,
                 comp: 32'd655360, fric: 32'd39322};
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        RegKn:   cfg_q.kn   <= cfg_data_i;
        RegKs:   cfg_q.ks   <= cfg_data_i;
        RegT:    cfg_q.ten  <= cfg_data_i;
        RegC:    cfg_q.coh  <= cfg_data_i;
        RegU:    cfg_q.comp <= cfg_data_i;
        RegF:    cfg_q.fric <= cfg_data_i;
        default: ;
      endcase
    end
  end

  logic en;
  assign en = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = en;

  // stage 1: cross products and translations
  logic v1_q;
  logic signed [45:0] c1_q [2][3][2];
  logic signed [20:0] s1_q [2][3];
  logic [VecBits-1:0] n1_q;
  logic [16:0] life1_q;
  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int c = 0; c < 2; c++) begin
        for (int k = 0; k < 3; k++) begin
          logic [VecBits-1:0] tw, rw;
          tw = c == 0 ? s_axis_tdata[VecBits +: VecBits] : s_axis_tdata[3*VecBits +: VecBits];
          rw = c == 0 ? s_axis_tdata[4*VecBits +: VecBits] :
                        s_axis_tdata[5*VecBits +: VecBits];
          s1_q[c][k] <= get_comp(c == 0 ? s_axis_tdata[0 +: VecBits] :
                                          s_axis_tdata[2*VecBits +: VecBits], k);
          c1_q[c][k][0] <= 46'(get_comp(tw, (k+1)%3)) * 46'(get_comp(rw, (k+2)%3));
          c1_q[c][k][1] <= 46'(get_comp(tw, (k+2)%3)) * 46'(get_comp(rw, (k+1)%3));
        end
      end
      n1_q    <= s_axis_tdata[6*VecBits +: VecBits];
      life1_q <= s_axis_tdata[7*VecBits +: LifeBits];
    end
  end

  // stage 2: d16 = floor((dj - di) / 2^16)
  logic v2_q;
  logic signed [33:0] d2_q [3];
  logic [VecBits-1:0] n2_q;
  logic [16:0] life2_q;
  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        logic signed [49:0] di, dj, df;
        di = (50'(s1_q[0][k]) <<< 16) + 50'(c1_q[0][k][0]) - 50'(c1_q[0][k][1]);
        dj = (50'(s1_q[1][k]) <<< 16) + 50'(c1_q[1][k][0]) - 50'(c1_q[1][k][1]);
        df = dj - di;
        d2_q[k] <= 34'(df >>> 16);
      end
      n2_q <= n1_q; life2_q <= life1_q;
    end
  end

  // stage 3: products d16*n
  logic v3_q;
  logic signed [54:0] p3_q [3];
  logic signed [33:0] d3_q [3];
  logic [VecBits-1:0] n3_q;
  logic [16:0] life3_q;
  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int k = 0; k < 3; k++) p3_q[k] <= 55'(d2_q[k]) * 55'(get_comp(n2_q, k));
      d3_q <= d2_q; n3_q <= n2_q; life3_q <= life2_q;
    end
  end

  // stage 4: dn16
  logic v4_q;
  logic signed [37:0] dn4_q;
  logic signed [33:0] d4_q [3];
  logic [VecBits-1:0] n4_q;
  logic [16:0] life4_q;
  always_ff @(posedge clk_i) begin
    if (en) begin
      logic signed [56:0] s;
      s = 57'(p3_q[0]) + 57'(p3_q[1]) + 57'(p3_q[2]);
      dn4_q <= 38'(s >>> NormFrac);
      d4_q <= d3_q; n4_q <= n3_q; life4_q <= life3_q;
    end
  end

  // stage 5: dn16*n and kn*dn16
  logic v5_q;
  logic signed [58:0] q5_q [3];
  logic signed [70:0] sg5_q;
  logic signed [33:0] d5_q [3];
  logic [16:0] life5_q;
  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int k = 0; k < 3; k++) q5_q[k] <= 59'(dn4_q) * 59'(get_comp(n4_q, k));
      sg5_q <= -(71'($signed({1'b0, cfg_q.kn})) * 71'(dn4_q));
      d5_q <= d4_q; life5_q <= life4_q;
    end
  end

  // stage 6: tangential magnitudes, sigma saturation
  logic v6_q;
  logic [40:0] ta6_q [3];
  logic signed [31:0] sig6_q;
  logic [16:0] life6_q;
  always_ff @(posedge clk_i) begin
    if (en) begin
      logic signed [59:0] tq;
      logic signed [40:0] tf;
      logic signed [54:0] sw;
      for (int k = 0; k < 3; k++) begin
        tq = (60'(d5_q[k]) <<< NormFrac) - 60'(q5_q[k]);
        tf = 41'(tq >>> NormFrac);
        ta6_q[k] <= tf < 0 ? 41'(-tf) : 41'(tf);
      end
      sw = 55'(sg5_q >>> 16);
      if (sw > 55'sh7FFFFFFF) sig6_q <= 32'sh7FFFFFFF;
      else if (sw < -55'sh80000000) sig6_q <= 32'sh80000000;
      else sig6_q <= 32'(sw);
      life6_q <= life5_q;
    end
  end

  // stage 7: normalize exponent
  logic v7_q;
  logic [30:0] ta7_q [3];
  logic [3:0] e7_q;
  logic signed [31:0] sig7_q;
  logic [16:0] life7_q;
  always_ff @(posedge clk_i) begin
    if (en) begin
      logic [40:0] mx;
      logic [3:0] e;
      mx = ta6_q[0] | ta6_q[1] | ta6_q[2];
      e = '0;
      for (int b = 31; b <= 40; b++) if (mx[b]) e = 4'(b - 30);
      for (int k = 0; k < 3; k++) ta7_q[k] <= 31'(ta6_q[k] >> e);
      e7_q <= e; sig7_q <= sig6_q; life7_q <= life6_q;
    end
  end

  // stage 8: sum of squares
  logic v8_q;
  logic [63:0] ss8_q;
  logic [3:0] e8_q;
  logic signed [31:0] sig8_q;
  logic [16:0] life8_q;
  always_ff @(posedge clk_i) begin
    if (en) begin
      ss8_q <= 64'(ta7_q[0]) * 64'(ta7_q[0]) + 64'(ta7_q[1]) * 64'(ta7_q[1])
             + 64'(ta7_q[2]) * 64'(ta7_q[2]);
      e8_q <= e7_q; sig8_q <= sig7_q; life8_q <= life7_q;
    end
  end

  logic v9;
  logic [31:0] root9;
  logic [191:0] side9;
  bsf_sqrt_pipe u_sqrt (
    .clk_i, .rst_ni, .en_i(en), .valid_i(v8_q), .rad_i(ss8_q),
    .side_i({139'd0, life8_q, sig8_q, e8_q}),
    .valid_o(v9), .root_o(root9), .side_o(side9)
  );

  // stage 10: shear product, strengths, friction
  logic v10_q;
  logic [63:0] sh10_q;
  logic [3:0] e10_q;
  logic signed [31:0] sig10_q;
  logic [47:0] st10_q, sc10_q, su10_q;
  logic signed [64:0] fr10_q;
  always_ff @(posedge clk_i) begin
    if (en) begin
      logic [16:0] lf;
      logic signed [31:0] sg;
      lf = side9[52:36] > 17'd65536 ? 17'd65536 : side9[52:36];
      sg = side9[35:4];
      sh10_q  <= 64'(cfg_q.ks) * 64'(root9);
      e10_q   <= side9[3:0];
      sig10_q <= sg;
      st10_q  <= 48'((49'(cfg_q.ten) * 49'(lf)) >> 16);
      sc10_q  <= 48'((49'(cfg_q.coh) * 49'(lf)) >> 16);
      su10_q  <= 48'((49'(cfg_q.comp) * 49'(lf)) >> 16);
      fr10_q  <= 65'(sg) * 65'($signed({1'b0, cfg_q.fric}));
    end
  end

  // stage 11: tau and tests
  logic v11_q;
  logic signed [31:0] sig11_q;
  logic [30:0] tau11_q;
  logic [1:0] cause11_q;
  always_ff @(posedge clk_i) begin
    if (en) begin
      logic [79:0] shifted;
      logic [63:0] sw;
      logic [30:0] tau;
      logic signed [50:0] lim;
      shifted = {16'd0, sh10_q} << e10_q;
      sw = shifted[79:16];
      tau = (shifted[79:64] != 0 || sw > 64'h7FFFFFFF) ? 31'h7FFFFFFF : 31'(sw);
      lim = 51'($signed({1'b0, sc10_q})) - 51'(fr10_q >>> 16);
      if (51'(sig10_q) > 51'($signed({1'b0, st10_q}))) cause11_q <= CauseTensile;
      else if (51'($signed({1'b0, tau})) > lim) cause11_q <= CauseShear;
      else if (51'(sig10_q) < -51'($signed({1'b0, su10_q}))) cause11_q <= CauseComp;
      else cause11_q <= CauseNone;
      sig11_q <= sig10_q;
      tau11_q <= tau;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      {v1_q, v2_q, v3_q, v4_q, v5_q, v6_q, v7_q, v8_q, v10_q, v11_q} <= '0;
    end else if (en) begin
      v1_q <= s_axis_tvalid; v2_q <= v1_q; v3_q <= v2_q; v4_q <= v3_q;
      v5_q <= v4_q; v6_q <= v5_q; v7_q <= v6_q; v8_q <= v7_q;
      v10_q <= v9; v11_q <= v10_q;
    end
  end

  assign m_axis_tvalid = v11_q;
  assign m_axis_tdata  = {(OutBytes*8-OutBits)'(0), cause11_q, cause11_q != CauseNone,
                          tau11_q, sig11_q};
endmodule
